[hdl/a2p_pkg.sv]
// shared constants and types for the polynomial arctangent block
// no dependencies
package a2p_pkg;

  localparam int DEF_INPUT_WIDTH     = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  // ratio and polynomial work in q30
  localparam int QF    = 30;
  localparam int QW    = QF + 1;   // ratio bits, ratio reaches 1.0
  localparam int TW    = 33;       // signed horner accumulator
  localparam int NCOEF = 6;

  localparam logic [31:0] PI_Q      = 32'hC90FDAA2;
  localparam logic [31:0] HALF_PI_Q = 32'h6487ED51;

  // horner coefficients, highest power first, signs folded in
  localparam logic signed [TW-1:0] COEF [NCOEF] = '{
    -33'sd14474544,
     33'sd61715796,
    -33'sd130179461,
     33'sd210062475,
    -33'sd357550226,
     33'sd1073737132
  };

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
    logic swap;
  } ctl_t;

endpackage

[hdl/a2p_vec_if.sv]
// input channel: one vector per beat
// no dependencies
interface a2p_vec_if #(parameter int INPUT_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] vec_x;
  logic signed [INPUT_WIDTH-1:0] vec_y;
  modport source (output valid, vec_x, vec_y, input ready);
  modport sink   (input valid, vec_x, vec_y, output ready);
endinterface

[hdl/a2p_ang_if.sv]
// output channel: one angle per beat
// no dependencies
interface a2p_ang_if #(parameter int ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;
  logic                          undefined;
  modport source (output valid, angle, undefined, input ready);
  modport sink   (input valid, angle, undefined, output ready);
endinterface

[hdl/atan2_polynomial.sv]
// four-quadrant arctangent top level
// uses a2p_pkg, a2p_vec_if, a2p_ang_if, a2p_div_stage
//
// usage
//   vec carries one (vec_x, vec_y) pair per beat, two's complement.
//   result carries the angle in radians, signed with ANGLE_FRAC_BITS
//   fraction bits, range -pi..pi, and an undefined flag set for (0,0),
//   in which case the angle is 0.
// throughput and pipeline
//   one beat per cycle while result is not stalled. 40 register stages: input register,
//   31 divider stages (one quotient bit each), ratio squaring, five horner
//   multiply stages, final multiply, and the reflect/round output register.
// stall
//   the whole pipeline advances together; when result holds valid with
//   ready low every stage freezes and vec.ready drops, so nothing is lost
//   or repeated. bubbles in the pipe keep moving while the output is empty.
// reset
//   synchronous rst clears every stage valid; payload is not reset.
module atan2_polynomial #(
  parameter int INPUT_WIDTH     = a2p_pkg::DEF_INPUT_WIDTH,
  parameter int ANGLE_FRAC_BITS = a2p_pkg::DEF_ANGLE_FRAC_BITS
) (
  input logic       clk,
  input logic       rst,
  a2p_vec_if.sink   vec,
  a2p_ang_if.source result
);
  import a2p_pkg::*;

  localparam int W  = INPUT_WIDTH;
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = QF - ANGLE_FRAC_BITS;
  localparam int ND = QW;   // divider stages

  logic adv;
  assign adv       = !result.valid || result.ready;
  assign vec.ready = adv;

  // input register: magnitudes, ordering and signs
  logic [W-1:0] ax, ay;
  always_comb begin
    // negating the most negative value wraps to 2^(W-1), which is exact unsigned
    ax = vec.vec_x[W-1] ? W'(-vec.vec_x) : W'(vec.vec_x);
    ay = vec.vec_y[W-1] ? W'(-vec.vec_y) : W'(vec.vec_y);
  end

  logic         dv   [ND+1];
  ctl_t         dc   [ND+1];
  logic [W-1:0] db   [ND+1];
  logic [W-1:0] drem [ND+1];
  logic [QW-1:0] dq  [ND+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= vec.valid;
    end
    if (adv) begin
      dc[0].zero <= (ax == '0) && (ay == '0);
      dc[0].xneg <= vec.vec_x[W-1];
      dc[0].yneg <= vec.vec_y[W-1];
      dc[0].swap <= ay > ax;
      db[0]      <= (ax >= ay) ? ax : ay;
      drem[0]    <= (ax <= ay) ? ax : ay;
    end
  end
  assign dq[0] = '0;

  // ratio = floor(small * 2^30 / big), one bit per stage
  for (genvar k = 0; k < ND; k++) begin : g_div
    a2p_div_stage #(.W(W), .FIRST(k == 0)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (dv[k]),
      .ctl_in   (dc[k]),
      .big_in   (db[k]),
      .rem_in   (drem[k]),
      .q_in     (dq[k]),
      .valid    (dv[k+1]),
      .ctl      (dc[k+1]),
      .big      (db[k+1]),
      .rem      (drem[k+1]),
      .q        (dq[k+1])
    );
  end

  // horner pipeline; stage 0 holds the squared ratio and the leading coefficient
  logic                 hv [NCOEF];
  ctl_t                 hc [NCOEF];
  logic [QW-1:0]        hr [NCOEF];
  logic [QW-1:0]        hs [NCOEF];
  logic signed [TW-1:0] ht [NCOEF];

  logic [2*QW-1:0] sq;
  assign sq = dq[ND] * dq[ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (adv) begin
      hv[0] <= dv[ND];
    end
    if (adv) begin
      hc[0] <= dc[ND];
      hr[0] <= dq[ND];
      hs[0] <= sq[QF +: QW];
      ht[0] <= COEF[0];
    end
  end

  for (genvar h = 1; h < NCOEF; h++) begin : g_horner
    logic signed [2*TW-1:0] prod;
    // arithmetic shift of the product is the floor the polynomial needs
    assign prod = ht[h-1] * $signed({{(TW-QW){1'b0}}, hs[h-1]});
    always_ff @(posedge clk) begin
      if (rst) begin
        hv[h] <= 1'b0;
      end else if (adv) begin
        hv[h] <= hv[h-1];
      end
      if (adv) begin
        hc[h] <= hc[h-1];
        hr[h] <= hr[h-1];
        hs[h] <= hs[h-1];
        ht[h] <= prod[QF +: TW] + COEF[h];
      end
    end
  end

  // first-octant angle = poly * ratio
  logic signed [2*TW-1:0] fprod;
  assign fprod = ht[NCOEF-1] * $signed({{(TW-QW){1'b0}}, hr[NCOEF-1]});

  logic                 fv;
  ctl_t                 fc;
  logic signed [TW-1:0] ft;
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= hv[NCOEF-1];
    end
    if (adv) begin
      fc <= hc[NCOEF-1];
      ft <= fprod[QF +: TW];
    end
  end

  // clamp, reflect into the right octant and quadrant, round, then sign
  logic [31:0]   a_clamp, a_oct, a_quad;
  logic [32:0]   a_round;
  logic [AW-1:0] mag;
  logic [AW-1:0] angle_next;
  always_comb begin
    if (ft < 0) begin
      a_clamp = '0;
    end else if (ft > $signed({1'b0, HALF_PI_Q})) begin
      a_clamp = HALF_PI_Q;
    end else begin
      a_clamp = ft[31:0];
    end
    a_oct      = fc.swap ? HALF_PI_Q - a_clamp : a_clamp;
    a_quad     = fc.xneg ? PI_Q - a_oct : a_oct;
    a_round    = {1'b0, a_quad} + (33'd1 << (SH - 1));
    mag        = a_round[SH +: AW];
    angle_next = fc.yneg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= fv;
    end
    if (adv) begin
      result.angle     <= fc.zero ? '0 : $signed(angle_next);
      result.undefined <= fc.zero;
    end
  end
endmodule

[hdl/a2p_div_stage.sv]
// one quotient bit of the pipelined restoring divider
// uses a2p_pkg
module a2p_div_stage #(
  parameter int W     = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  a2p_pkg::ctl_t        ctl_in,
  input  logic [W-1:0]         big_in,
  input  logic [W-1:0]         rem_in,
  input  logic [a2p_pkg::QW-1:0] q_in,
  output logic                 valid,
  output a2p_pkg::ctl_t        ctl,
  output logic [W-1:0]         big,
  output logic [W-1:0]         rem,
  output logic [a2p_pkg::QW-1:0] q
);
  import a2p_pkg::*;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  always_comb begin
    // first bit compares the smaller magnitude directly, the rest shift
    trial = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
    ge    = trial >= {1'b0, big_in};
    diff  = trial - {1'b0, big_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      ctl <= ctl_in;
      big <= big_in;
      rem <= ge ? diff[W-1:0] : trial[W-1:0];
      q   <= {q_in[QW-2:0], ge};
    end
  end
endmodule

[sim/atan2_polynomial_tb.sv]
// self-checking testbench for the polynomial arctangent block
// depends on a2p_pkg, a2p_vec_if, a2p_ang_if and atan2_polynomial
`timescale 1ns / 100ps

module atan2_polynomial_tb;
  import a2p_pkg::*;

  localparam int IW = 16;
  localparam int FB = 13;
  localparam int AW = FB + 3;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    logic                 undefined;
  } angle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  a2p_vec_if #(.INPUT_WIDTH(IW)) vec ();
  a2p_ang_if #(.ANGLE_WIDTH(AW)) result ();

  atan2_polynomial #(.INPUT_WIDTH(IW), .ANGLE_FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .vec(vec), .result(result)
  );

  always #5 clk = ~clk;

  angle_t expected_angles[$];
  int     failures = 0;
  int     cycles = 0;
  bit     calm = 1'b0;   // no idling in the last part of the run

  // q30 coefficients, rounded to nearest from the decimal constants
  function automatic longint qcoef(longint n);
    return (n * (64'sd1 << 30) + 500000000) / 1000000000;
  endfunction

  // floor of v / 2^30 for either sign
  function automatic longint floor30(longint v);
    return v >>> 30;
  endfunction

  // compute the expected angle and flag for one vector
  function automatic angle_t predict_angle(logic signed [IW-1:0] x, logic signed [IW-1:0] y);
    angle_t        res;
    longint        ax, ay, big, lil, r, s, t, a, mag;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    res = '0;
    if (ax == 0 && ay == 0) begin
      res.undefined = 1'b1;
      return res;
    end
    big = (ax >= ay) ? ax : ay;
    lil = (ax <= ay) ? ax : ay;
    r = (lil << 30) / big;
    s = (r * r) >> 30;
    t = -qcoef(13480470);
    t = floor30(t * s) + qcoef(57477314);
    t = floor30(t * s) - qcoef(121239071);
    t = floor30(t * s) + qcoef(195635925);
    t = floor30(t * s) - qcoef(332994597);
    t = floor30(t * s) + qcoef(999995630);
    t = floor30(t * r);
    if (t < 0) t = 0;
    a = t;
    if (a > longint'(HALF_PI_Q)) a = longint'(HALF_PI_Q);
    if (ay > ax) a = longint'(HALF_PI_Q) - a;   // reflect across the diagonal
    if (x < 0) a = longint'(PI_Q) - a;         // left half plane
    // round the magnitude first, then apply the sign so results are symmetric
    mag = (a + (64'sd1 << (30 - FB - 1))) >> (30 - FB);
    if (y < 0) mag = -mag;
    res.angle = mag[AW-1:0];
    return res;
  endfunction

  // random idle burst, some of the time
  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) begin
      vec.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // offer one vector and hold it until accepted
  task automatic send_vector(logic signed [IW-1:0] x, logic signed [IW-1:0] y);
    idle_burst();
    vec.valid <= 1'b1;
    vec.vec_x <= x;
    vec.vec_y <= y;
    @(posedge clk);
    while (!vec.ready) @(posedge clk);
    expected_angles.push_back(predict_angle(x, y));
    @(negedge clk);
  endtask

  // result sink: random back pressure, compare each beat against the oldest expectation
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (calm) result.ready <= 1'b1;
    else result.ready <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    angle_t want;
    cycles <= cycles + 1;
    if (!rst && result.valid && result.ready) begin
      if (expected_angles.size() == 0) begin
        $error("result beat with nothing expected: angle %0d", result.angle);
        failures++;
      end else begin
        want = expected_angles.pop_front();
        if (result.angle !== want.angle) begin
          $error("angle mismatch: expected %0d, got %0d", want.angle, result.angle);
          failures++;
        end
        if (result.undefined !== want.undefined) begin
          $error("undefined mismatch: expected %0d, got %0d", want.undefined, result.undefined);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    vec.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // extremes, axes, diagonals and the zero vector
  task automatic test_directed();
    logic signed [IW-1:0] vals[5] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1};
    foreach (vals[i]) foreach (vals[j]) send_vector(vals[i], vals[j]);
  endtask

  // random vectors, mostly full range, some small so ratios sweep finely
  task automatic test_random(int n);
    logic signed [IW-1:0] x, y;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin
          x = IW'(int'($urandom_range(0, 20)) - 10);
          y = IW'(int'($urandom_range(0, 20)) - 10);
        end
        1: begin
          x = IW'($urandom);
          y = $urandom_range(0, 1) ? x : -x;   // equal magnitudes
        end
        default: begin
          x = IW'($urandom);
          y = IW'($urandom);
        end
      endcase
      send_vector(x, y);
    end
  endtask

  // sender waits for the pipe to empty before continuing
  task automatic test_pause();
    test_random(10);
    drain();
    test_random(10);
  endtask

  initial begin
    vec.valid = 1'b0;
    vec.vec_x = '0;
    vec.vec_y = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pause();
    test_random(600);
    calm = 1'b1;
    test_random(200);
    drain();
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
